>>> design/sfr_pkg.sv
// ---------------------------------------------------------------------------
// Serial frame receiver package
// Shared constants, the flush request type and the frame check update.
// ---------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    // Default transfer unit: the body store depth, body limit is two less.
    localparam int TRANSMISSION_UNIT_DEF = 64;

    // Width of frame positions carried between modules (unit is at most 256).
    localparam int FRAME_POS_W = 8;

    localparam logic [7:0] FLAG_BYTE  = 8'h7E;
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] ESC_XOR    = 8'h20;
    localparam logic [7:0] DEST_BCAST = 8'hFF;
    localparam logic [7:0] DEST_NULL  = 8'h00;
    localparam int         MIN_BODY   = 5;

    localparam logic [15:0] CHECK_POLY       = 16'h8408;
    localparam logic [15:0] CHECK_SEED_RESET = 16'hFFFF;
    localparam logic [7:0]  OWN_ADDR_RESET   = 8'h00;

    // Configuration register indexes (byte address bit 2).
    localparam logic REG_OWN_ADDRESS = 1'b0;
    localparam logic REG_CHECK_SEED  = 1'b1;

    // Request from the parser to the flush sequencer.
    typedef struct packed {
        logic                   start;
        logic [FRAME_POS_W-1:0] last_pos;
        logic [7:0]             version;
    } flush_req_t;

    // One byte through the reflected 16-bit HDLC frame check.
    function automatic logic [15:0] check_add(input logic [15:0] c_in,
                                              input logic [7:0]  b);
        logic [15:0] c;
        c = c_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CHECK_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> design/sfr_body_mem.sv
// ---------------------------------------------------------------------------
// Serial frame receiver body store
// One write port and one read port, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module sfr_body_mem #(
    parameter int DEPTH = sfr_pkg::TRANSMISSION_UNIT_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> design/sfr_parser.sv
// ---------------------------------------------------------------------------
// Serial frame receiver parser
// Frame phase machine, un-escaping, frame check and close decision.
// ---------------------------------------------------------------------------
`default_nettype none

module sfr_parser #(
    parameter int TRANSMISSION_UNIT = sfr_pkg::TRANSMISSION_UNIT_DEF,
    parameter int AW                = $clog2(TRANSMISSION_UNIT)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                in_take,
    input  wire logic [7:0]          in_byte,
    input  wire logic [7:0]          own_address,
    input  wire logic [15:0]         check_seed,
    output logic                     wr_en,
    output logic      [AW-1:0]       wr_addr,
    output logic      [7:0]          wr_data,
    output sfr_pkg::flush_req_t      flush_req
);

    localparam logic [2:0] PH_HUNT     = 3'd0;
    localparam logic [2:0] PH_VERSION  = 3'd1;
    localparam logic [2:0] PH_COUNT    = 3'd2;
    localparam logic [2:0] PH_BODY     = 3'd3;
    localparam logic [2:0] PH_ESCAPE   = 3'd4;
    localparam logic [2:0] PH_CHECK_HI = 3'd5;
    localparam logic [2:0] PH_CHECK_LO = 3'd6;
    localparam logic [2:0] PH_CLOSE    = 3'd7;

    localparam logic [7:0]    MAX_BODY_B = 8'(TRANSMISSION_UNIT - 2);
    localparam logic [AW-1:0] MIN_POS    = AW'(sfr_pkg::MIN_BODY);

    logic [2:0]    phase_reg,   phase_next;
    logic [AW-1:0] remain_reg,  remain_next;
    logic [AW-1:0] wpos_reg,    wpos_next;
    logic [7:0]    version_reg, version_next;
    logic [7:0]    dest_reg,    dest_next;
    logic [15:0]   crc_reg,     crc_next;
    logic [15:0]   rxchk_reg,   rxchk_next;

    logic       start;
    logic       take;
    logic [7:0] take_byte;
    logic       dest_ok;

    assign dest_ok = (dest_reg == sfr_pkg::DEST_NULL) || (dest_reg == sfr_pkg::DEST_BCAST) ||
                     (dest_reg == own_address);

    always_comb begin
        phase_next   = phase_reg;
        remain_next  = remain_reg;
        wpos_next    = wpos_reg;
        version_next = version_reg;
        dest_next    = dest_reg;
        crc_next     = crc_reg;
        rxchk_next   = rxchk_reg;
        start        = 1'b0;
        take         = 1'b0;
        take_byte    = in_byte;
        flush_req    = '0;

        if (in_take) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    start = (in_byte == sfr_pkg::FLAG_BYTE);
                end
                PH_VERSION: begin
                    version_next = in_byte;
                    crc_next     = sfr_pkg::check_add(crc_reg, in_byte);
                    phase_next   = PH_COUNT;
                end
                PH_COUNT: begin
                    crc_next = sfr_pkg::check_add(crc_reg, in_byte);
                    if ((in_byte == 8'd0) || (in_byte > MAX_BODY_B)) begin
                        phase_next = PH_HUNT;
                    end else begin
                        remain_next = in_byte[AW-1:0];
                        phase_next  = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (in_byte == sfr_pkg::ESC_BYTE) begin
                        phase_next = PH_ESCAPE;
                    end else if (in_byte == sfr_pkg::FLAG_BYTE) begin
                        start = 1'b1;
                    end else begin
                        take = 1'b1;
                    end
                end
                PH_ESCAPE: begin
                    if ((in_byte == (sfr_pkg::ESC_BYTE ^ sfr_pkg::ESC_XOR)) ||
                        (in_byte == (sfr_pkg::FLAG_BYTE ^ sfr_pkg::ESC_XOR))) begin
                        take      = 1'b1;
                        take_byte = in_byte + sfr_pkg::ESC_XOR;
                    end else if (in_byte == sfr_pkg::FLAG_BYTE) begin
                        start = 1'b1;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_CHECK_HI: begin
                    rxchk_next = {in_byte, 8'h00};
                    phase_next = PH_CHECK_LO;
                end
                PH_CHECK_LO: begin
                    rxchk_next = {rxchk_reg[15:8], in_byte};
                    phase_next = PH_CLOSE;
                end
                PH_CLOSE: begin
                    phase_next = PH_HUNT;
                    if ((in_byte == sfr_pkg::FLAG_BYTE) && (wpos_reg >= MIN_POS) &&
                        (rxchk_reg == crc_reg) && dest_ok) begin
                        flush_req.start = 1'b1;
                    end
                end
            endcase
        end

        if (start) begin
            remain_next = '0;
            wpos_next   = '0;
            crc_next    = check_seed;
            rxchk_next  = '0;
            phase_next  = PH_VERSION;
        end

        if (take) begin
            wpos_next   = wpos_reg + 1'b1;
            crc_next    = sfr_pkg::check_add(crc_reg, take_byte);
            remain_next = remain_reg - 1'b1;
            phase_next  = (remain_reg == AW'(1)) ? PH_CHECK_HI : PH_BODY;
            if (wpos_reg == AW'(1)) begin
                dest_next = take_byte;
            end
        end

        flush_req.last_pos = sfr_pkg::FRAME_POS_W'(wpos_reg) - 1'b1;
        flush_req.version  = version_reg;
    end

    assign wr_en   = take;
    assign wr_addr = wpos_reg;
    assign wr_data = take_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            remain_reg  <= '0;
            wpos_reg    <= '0;
            version_reg <= '0;
            dest_reg    <= '0;
            crc_reg     <= sfr_pkg::CHECK_SEED_RESET;
            rxchk_reg   <= '0;
        end else begin
            phase_reg   <= phase_next;
            remain_reg  <= remain_next;
            wpos_reg    <= wpos_next;
            version_reg <= version_next;
            dest_reg    <= dest_next;
            crc_reg     <= crc_next;
            rxchk_reg   <= rxchk_next;
        end
    end

endmodule

`default_nettype wire

>>> design/sfr_flush.sv
// ---------------------------------------------------------------------------
// Serial frame receiver flush sequencer
// Reads the stored body out of the memory into the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module sfr_flush #(
    parameter int TRANSMISSION_UNIT = sfr_pkg::TRANSMISSION_UNIT_DEF,
    parameter int AW                = $clog2(TRANSMISSION_UNIT)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire sfr_pkg::flush_req_t flush_req,
    output logic                     busy,
    output logic                     rd_en,
    output logic      [AW-1:0]       rd_addr,
    input  wire logic [7:0]          rd_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic      [7:0]          m_body_byte,
    output logic      [5:0]          m_body_index,
    output logic      [7:0]          m_header_version,
    output logic                     m_last_byte
);

    localparam int KXW = AW + 6;

    logic          busy_reg;
    logic          pend_reg;
    logic [AW-1:0] k_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [AW-1:0] last_reg;
    logic [7:0]    version_reg;
    logic          m_valid_reg;
    logic [7:0]    byte_reg;
    logic [5:0]    index_reg;
    logic [7:0]    version_out_reg;
    logic          last_out_reg;
    logic [KXW-1:0] idx_ext;

    assign rd_en   = busy_reg && !pend_reg && (k_reg <= last_reg) && (!m_valid_reg || m_ready);
    assign rd_addr = k_reg;
    assign idx_ext = KXW'(rd_idx_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (flush_req.start) begin
                busy_reg <= 1'b1;
            end else if (pend_reg && (rd_idx_reg == last_reg)) begin
                busy_reg <= 1'b0;
            end
            pend_reg <= rd_en;
            if (pend_reg) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // The version travels with each byte, so a new frame's request cannot
    // disturb a result that is still waiting for its transfer.
    always_ff @(posedge aclk) begin
        if (flush_req.start) begin
            k_reg       <= '0;
            last_reg    <= flush_req.last_pos[AW-1:0];
            version_reg <= flush_req.version;
        end else if (rd_en) begin
            k_reg <= k_reg + 1'b1;
        end
        if (rd_en) begin
            rd_idx_reg <= k_reg;
        end
        if (pend_reg) begin
            byte_reg        <= rd_data;
            index_reg       <= idx_ext[5:0];
            version_out_reg <= version_reg;
            last_out_reg    <= (rd_idx_reg == last_reg);
        end
    end

    assign busy             = busy_reg;
    assign m_valid          = m_valid_reg;
    assign m_body_byte      = byte_reg;
    assign m_body_index     = index_reg;
    assign m_header_version = version_out_reg;
    assign m_last_byte      = last_out_reg;

endmodule

`default_nettype wire

>>> design/serial_frame_receiver_fcs_check.sv
// ---------------------------------------------------------------------------
// Serial frame receiver with frame check
// Deframes flag-delimited serial bytes, checks the FCS and destination and
// streams the body of each accepted frame out one byte per transfer.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Carries
//  s_        in         s_valid / s_ready    s_rx_byte: one raw line byte
//  m_        out        m_valid / m_ready    body byte, index, version, last
//  APB       in         psel/penable/pready  own_address (0x0), check_seed (0x4)
//
// Outside a flush every input transfer is taken as it is offered: the parser
// updates its phase, frame check and body store write in the same cycle.
// A closing flag of an accepted frame starts a flush that reads the body
// store back, each body byte through a memory read and then the result
// register, and s_ready stays low until the last body byte has been read.
// Reset is synchronous and active low; the body store needs no clearing pass
// as only entries written in the current frame are read.
// Back-pressure on m_ready holds the flush; the input side waits meanwhile.
// ---------------------------------------------------------------------------
`default_nettype none

module serial_frame_receiver_fcs_check #(
    parameter int TRANSMISSION_UNIT = sfr_pkg::TRANSMISSION_UNIT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    // Result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [7:0]  m_body_byte,
    output logic      [5:0]  m_body_index,
    output logic      [7:0]  m_header_version,
    output logic             m_last_byte,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int AW = $clog2(TRANSMISSION_UNIT);

    // Configuration registers.
    logic [7:0]  own_address_reg;
    logic [15:0] check_seed_reg;
    logic        cfg_write;

    // Interconnect between parser, body store and flush sequencer.
    logic                in_take;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [7:0]          wr_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [7:0]          rd_data;
    logic                flush_busy;
    sfr_pkg::flush_req_t flush_req;

    // The APB port never inserts wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_address_reg <= sfr_pkg::OWN_ADDR_RESET;
            check_seed_reg  <= sfr_pkg::CHECK_SEED_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                sfr_pkg::REG_OWN_ADDRESS: own_address_reg <= pwdata[7:0];
                sfr_pkg::REG_CHECK_SEED:  check_seed_reg  <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            sfr_pkg::REG_OWN_ADDRESS: prdata = {24'h000000, own_address_reg};
            sfr_pkg::REG_CHECK_SEED:  prdata = {16'h0000, check_seed_reg};
        endcase
    end

    // New line bytes are held off only while a frame body is being flushed.
    assign s_ready = !flush_busy;
    assign in_take = s_valid && s_ready;

    sfr_parser #(
        .TRANSMISSION_UNIT (TRANSMISSION_UNIT),
        .AW                (AW)
    ) u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_take     (in_take),
        .in_byte     (s_rx_byte),
        .own_address (own_address_reg),
        .check_seed  (check_seed_reg),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .flush_req   (flush_req)
    );

    sfr_body_mem #(
        .DEPTH (TRANSMISSION_UNIT),
        .AW    (AW)
    ) u_body_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sfr_flush #(
        .TRANSMISSION_UNIT (TRANSMISSION_UNIT),
        .AW                (AW)
    ) u_flush (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .flush_req        (flush_req),
        .busy             (flush_busy),
        .rd_en            (rd_en),
        .rd_addr          (rd_addr),
        .rd_data          (rd_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_body_byte      (m_body_byte),
        .m_body_index     (m_body_index),
        .m_header_version (m_header_version),
        .m_last_byte      (m_last_byte)
    );

    // A flush can only be requested while no earlier flush is running.
    a_flush_not_nested: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_req.start |-> !flush_busy)
        else $error("flush requested while a flush is running");

    // A request always puts the sequencer into its busy state.
    a_flush_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        flush_req.start |=> flush_busy)
        else $error("flush request not taken");

    // A new result only appears after a body store read.
    a_result_from_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(rd_en, 2))
        else $error("result shown without a memory read");

    // The body store is never written while it is being read back.
    a_no_write_in_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> !wr_en)
        else $error("body store written during flush");

endmodule

`default_nettype wire
